/* rtl/core/pfpt_pkg.sv */
package pfpt_pkg;

   // field and register widths
   localparam int MODE_W   = 2;
   localparam int NS_W     = 32;
   localparam int RATE_W   = 19;
   localparam int BUF_W    = 17;
   localparam int PERIOD_W = 17;
   localparam int LEAD_W   = 16;
   localparam int COUNT_W  = 21;
   localparam int POS_W    = 16;
   localparam int REM_W    = 30;

   // datapath widths
   localparam int PROD_W   = NS_W + RATE_W;
   localparam int SCALED_W = PROD_W + 1;
   localparam int FRAMES_W = SCALED_W - REM_W;
   localparam int WRAP_W   = FRAMES_W + 1;

   // ring positions fit in POS_W bits, so the usable length stops here
   localparam int POSITION_SPAN = 1 << POS_W;

   // configuration port
   localparam int DATA_W = 32;
   localparam int ADDR_W = 5;

   localparam logic [REM_W-1:0]   NS_PER_SECOND = 30'd1000000000;
   localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

   // item modes
   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_START = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;

   // register indexes
   localparam logic [2:0] REG_SAMPLE_RATE   = 3'd0;
   localparam logic [2:0] REG_BUFFER_FRAMES = 3'd1;
   localparam logic [2:0] REG_PERIOD_FRAMES = 3'd2;
   localparam logic [2:0] REG_START_LEAD    = 3'd3;
   localparam logic [2:0] REG_SUPPRESS      = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_NS,
      ST_WRAP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [RATE_W-1:0]   sample_rate;
      logic [BUF_W-1:0]    buffer_frames;
      logic [PERIOD_W-1:0] period_frames;
      logic [LEAD_W-1:0]   start_lead;
      logic                suppress;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      sample_rate:   19'd48000,
      buffer_frames: 17'd1024,
      period_frames: 17'd256,
      start_lead:    16'd0,
      suppress:      1'b0
   };

   // clip a count to the reported field width
   function automatic logic [COUNT_W-1:0] sat_count(input logic [WRAP_W-1:0] v);
      if (v > WRAP_W'(COUNT_MAX)) begin
         return COUNT_MAX;
      end
      return v[COUNT_W-1:0];
   endfunction

endpackage

/* rtl/core/pfpt_channels.sv */
interface pfpt_req_if;
   logic                         valid;
   logic                         ready;
   logic [pfpt_pkg::MODE_W-1:0]  mode;
   logic [pfpt_pkg::NS_W-1:0]    delta_ns;

   modport source (output valid, output mode, output delta_ns, input ready);
   modport sink   (input valid, input mode, input delta_ns, output ready);
endinterface

interface pfpt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pfpt_pkg::COUNT_W-1:0]  frames_advanced;
   logic [pfpt_pkg::COUNT_W-1:0]  periods_elapsed;
   logic [pfpt_pkg::POS_W-1:0]    position;
   logic                          running;

   modport source (output valid, output frames_advanced, output periods_elapsed,
                   output position, output running, input ready);
   modport sink   (input valid, input frames_advanced, input periods_elapsed,
                   input position, input running, output ready);
endinterface

/* rtl/core/pfpt_csr.sv */
module pfpt_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [pfpt_pkg::ADDR_W-1:0]   paddr,
   input  logic [pfpt_pkg::DATA_W-1:0]   pwdata,
   output logic [pfpt_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output pfpt_pkg::cfg_type             cfg
);
   localparam int DATA_W = pfpt_pkg::DATA_W;

   pfpt_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]        index;
   logic              wr;

   assign pready = 1'b1;
   assign index  = paddr[pfpt_pkg::ADDR_W-1:2];
   assign wr     = psel && penable && pwrite && pready;
   assign cfg    = cfg_ff;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (index)
            pfpt_pkg::REG_SAMPLE_RATE:
               cfg_in.sample_rate = pwdata[pfpt_pkg::RATE_W-1:0];
            pfpt_pkg::REG_BUFFER_FRAMES:
               cfg_in.buffer_frames = pwdata[pfpt_pkg::BUF_W-1:0];
            pfpt_pkg::REG_PERIOD_FRAMES:
               cfg_in.period_frames = pwdata[pfpt_pkg::PERIOD_W-1:0];
            pfpt_pkg::REG_START_LEAD:
               cfg_in.start_lead = pwdata[pfpt_pkg::LEAD_W-1:0];
            pfpt_pkg::REG_SUPPRESS:
               cfg_in.suppress = pwdata[0];
            default: begin
            end
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (index)
         pfpt_pkg::REG_SAMPLE_RATE:   prdata = DATA_W'(cfg_ff.sample_rate);
         pfpt_pkg::REG_BUFFER_FRAMES: prdata = DATA_W'(cfg_ff.buffer_frames);
         pfpt_pkg::REG_PERIOD_FRAMES: prdata = DATA_W'(cfg_ff.period_frames);
         pfpt_pkg::REG_START_LEAD:    prdata = DATA_W'(cfg_ff.start_lead);
         pfpt_pkg::REG_SUPPRESS:      prdata = DATA_W'(cfg_ff.suppress);
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= pfpt_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/core/pfpt_smul.sv */
module pfpt_smul #(
   parameter int A_W = 32,
   parameter int B_W = 19
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic [A_W+B_W-1:0] product,
   output logic               done
);
   localparam int CNT_W = $clog2(B_W + 1);

   logic [A_W-1:0]   a_ff, a_in;
   logic [A_W-1:0]   hi_ff, hi_in;
   logic [B_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [A_W:0]     sum;
   logic [B_W:0]     lo_shift;

   assign product = {hi_ff, lo_ff};
   assign done    = done_ff;

   // one multiplier bit per cycle, product shifts right into lo
   always_comb begin
      sum      = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);
      lo_shift = {sum[0], lo_ff};
      a_in     = a_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         a_in    = a;
         hi_in   = '0;
         lo_in   = b;
         cnt_in  = CNT_W'(B_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum[A_W:1];
         lo_in  = lo_shift[B_W:1];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

/* rtl/core/pfpt_sdiv.sv */
module pfpt_sdiv #(
   parameter int Q_W = 23,
   parameter int R_W = 17
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [R_W-1:0] rem_init,
   input  logic [Q_W-1:0] dividend,
   input  logic [R_W-1:0] divisor,
   output logic [Q_W-1:0] quotient,
   output logic [R_W-1:0] remainder,
   output logic           done
);
   localparam int CNT_W = $clog2(Q_W + 1);

   logic [R_W-1:0]   r_ff, r_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [R_W:0]     trial;
   logic [R_W+1:0]   diff;
   logic             fits;
   logic [Q_W:0]     q_shift;

   assign quotient  = q_ff;
   assign remainder = r_ff;
   assign done      = done_ff;

   // restoring division, one quotient bit per cycle; dividend bits
   // leave q from the top while quotient bits enter at the bottom
   always_comb begin
      trial   = {r_ff, q_ff[Q_W-1]};
      diff    = {1'b0, trial} - {2'b00, divisor};
      fits    = ~diff[R_W+1];
      q_shift = {q_ff, fits};
      r_in    = r_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         r_in    = rem_init;
         q_in    = dividend;
         cnt_in  = CNT_W'(Q_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in   = fits ? diff[R_W-1:0] : trial[R_W-1:0];
         q_in   = q_shift[Q_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      q_ff <= q_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

/* rtl/core/playback_frame_position_tracker.sv */
// channel   dir   protocol            payload
// req_ch    in    valid/ready         mode, delta_ns
// rsp_ch    out   valid/ready         frames_advanced, periods_elapsed, position, running
// csr       in    apb, pready high    sample_rate, buffer_frames, period_frames,
//                                     start lead, suppress_period_reports
//
// start, stop, idle ticks and other modes: once the item is taken the tracker
// goes to the done state and loads the output register once that register is free.
// tick that yields no frame: multiply and 10^9 split only.
// frame-advancing tick: the bit-serial multiply (one sample_rate bit per cycle,
// 19 bits) and two restoring divide stages (22 steps for the 10^9 split, then
// 23 steps for ring wrap and period count side by side on two dividers), each
// stage entered through its own state, then the done state loads the output register.
// one item at a time; the next item is taken once the result sits in the
// output register, even while that register waits on rsp_ch.ready.
// reset is synchronous and clears tracking state; registers go to defaults.
module playback_frame_position_tracker #(
   parameter int MAX_BUFFER_FRAMES = 65536
) (
   input  logic                          clock,
   input  logic                          reset,
   pfpt_req_if.sink                      req_ch,
   pfpt_rsp_if.source                    rsp_ch,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [pfpt_pkg::ADDR_W-1:0]   paddr,
   input  logic [pfpt_pkg::DATA_W-1:0]   pwdata,
   output logic [pfpt_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);
   localparam int POS_W    = pfpt_pkg::POS_W;
   localparam int BUF_W    = pfpt_pkg::BUF_W;
   localparam int PERIOD_W = pfpt_pkg::PERIOD_W;
   localparam int REM_W    = pfpt_pkg::REM_W;
   localparam int COUNT_W  = pfpt_pkg::COUNT_W;
   localparam int FRAMES_W = pfpt_pkg::FRAMES_W;
   localparam int WRAP_W   = pfpt_pkg::WRAP_W;
   localparam int SCALED_W = pfpt_pkg::SCALED_W;
   localparam int LEN_LIMIT = (MAX_BUFFER_FRAMES < pfpt_pkg::POSITION_SPAN) ?
                              MAX_BUFFER_FRAMES : pfpt_pkg::POSITION_SPAN;
   localparam logic [BUF_W-1:0] LEN_CAP = LEN_LIMIT[BUF_W-1:0];

   pfpt_pkg::cfg_type   cfg;
   pfpt_pkg::state_type state_ff, state_in;

   // tracking state
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [PERIOD_W-1:0] prog_ff, prog_in;
   logic                run_ff, run_in;

   // per-item working values
   logic [FRAMES_W-1:0] frames_ff, frames_in;
   logic [COUNT_W-1:0]  res_frames_ff, res_frames_in;
   logic [COUNT_W-1:0]  res_periods_ff, res_periods_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]  out_frames_ff, out_frames_in;
   logic [COUNT_W-1:0]  out_periods_ff, out_periods_in;
   logic [POS_W-1:0]    out_pos_ff, out_pos_in;
   logic                out_run_ff, out_run_in;

   logic [BUF_W-1:0]    len;
   logic [BUF_W-1:0]    len_m1;
   logic [BUF_W-1:0]    lead_ext;
   logic [BUF_W-1:0]    lead_clip;
   logic                tick_go;
   logic                accept;
   logic                out_free;
   logic                req_ready;
   logic                mul_start, ns_start, wrap_start, per_start, out_load;

   logic [pfpt_pkg::PROD_W-1:0] mul_prod;
   logic                        mul_done;
   logic [SCALED_W-1:0]         scaled;
   logic [FRAMES_W-1:0]         ns_quot;
   logic [REM_W-1:0]            ns_rem;
   logic                        ns_done;
   logic [WRAP_W-1:0]           wrap_dividend, per_dividend;
   logic [WRAP_W-1:0]           wrap_quot, per_quot;
   logic [BUF_W-1:0]            wrap_rem;
   logic [PERIOD_W-1:0]         per_rem;
   logic                        wrap_done, per_done;

   pfpt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // effective ring length and clipped lead
   always_comb begin
      len       = (cfg.buffer_frames > LEN_CAP) ? LEN_CAP : cfg.buffer_frames;
      len_m1    = len - 1'b1;
      lead_ext  = BUF_W'(cfg.start_lead);
      lead_clip = (lead_ext > len_m1) ? len_m1 : lead_ext;
   end

   assign accept   = req_ch.valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign tick_go  = run_ff && (req_ch.delta_ns != '0) && (cfg.sample_rate != '0) &&
                     (len != '0);

   // delta_ns * sample_rate
   pfpt_smul #(
      .A_W (pfpt_pkg::NS_W),
      .B_W (pfpt_pkg::RATE_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (req_ch.delta_ns),
      .b       (cfg.sample_rate),
      .product (mul_prod),
      .done    (mul_done)
   );

   // split scaled nanoseconds into frames and kept remainder
   assign scaled = {1'b0, mul_prod} + SCALED_W'(rem_ff);

   pfpt_sdiv #(
      .Q_W (FRAMES_W),
      .R_W (REM_W)
   ) u_ns_div (
      .clock     (clock),
      .reset     (reset),
      .start     (ns_start),
      .rem_init  (scaled[SCALED_W-1:FRAMES_W]),
      .dividend  (scaled[FRAMES_W-1:0]),
      .divisor   (pfpt_pkg::NS_PER_SECOND),
      .quotient  (ns_quot),
      .remainder (ns_rem),
      .done      (ns_done)
   );

   // ring wrap and period count run side by side
   assign wrap_dividend = WRAP_W'(pos_ff) + WRAP_W'(ns_quot);
   assign per_dividend  = WRAP_W'(prog_ff) + WRAP_W'(ns_quot);

   pfpt_sdiv #(
      .Q_W (WRAP_W),
      .R_W (BUF_W)
   ) u_wrap_div (
      .clock     (clock),
      .reset     (reset),
      .start     (wrap_start),
      .rem_init  ('0),
      .dividend  (wrap_dividend),
      .divisor   (len),
      .quotient  (wrap_quot),
      .remainder (wrap_rem),
      .done      (wrap_done)
   );

   pfpt_sdiv #(
      .Q_W (WRAP_W),
      .R_W (PERIOD_W)
   ) u_per_div (
      .clock     (clock),
      .reset     (reset),
      .start     (per_start),
      .rem_init  ('0),
      .dividend  (per_dividend),
      .divisor   (cfg.period_frames),
      .quotient  (per_quot),
      .remainder (per_rem),
      .done      (per_done)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfpt_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_ch.mode == pfpt_pkg::MODE_TICK && tick_go) ?
                          pfpt_pkg::ST_MUL : pfpt_pkg::ST_DONE;
            end
         end
         pfpt_pkg::ST_MUL: begin
            if (mul_done) state_in = pfpt_pkg::ST_NS;
         end
         pfpt_pkg::ST_NS: begin
            if (ns_done) begin
               state_in = (ns_quot == '0) ? pfpt_pkg::ST_DONE : pfpt_pkg::ST_WRAP;
            end
         end
         pfpt_pkg::ST_WRAP: begin
            if (wrap_done) state_in = pfpt_pkg::ST_DONE;
         end
         pfpt_pkg::ST_DONE: begin
            if (out_free) state_in = pfpt_pkg::ST_IDLE;
         end
         default: state_in = pfpt_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready  = 1'b0;
      mul_start  = 1'b0;
      ns_start   = 1'b0;
      wrap_start = 1'b0;
      per_start  = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         pfpt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            mul_start = req_ch.valid && (req_ch.mode == pfpt_pkg::MODE_TICK) && tick_go;
         end
         pfpt_pkg::ST_MUL: begin
            ns_start = mul_done;
         end
         pfpt_pkg::ST_NS: begin
            wrap_start = ns_done && (ns_quot != '0);
            per_start  = wrap_start && (cfg.period_frames != '0);
         end
         pfpt_pkg::ST_WRAP: begin
         end
         pfpt_pkg::ST_DONE: begin
            out_load = out_free;
         end
         default: begin
         end
      endcase
   end

   assign req_ch.ready = req_ready;

   // datapath updates
   always_comb begin
      pos_in         = pos_ff;
      rem_in         = rem_ff;
      prog_in        = prog_ff;
      run_in         = run_ff;
      frames_in      = frames_ff;
      res_frames_in  = res_frames_ff;
      res_periods_in = res_periods_ff;

      // item taken: counts start at zero (a start reports its lead), start and stop act at once
      if (state_ff == pfpt_pkg::ST_IDLE && accept) begin
         res_frames_in  = '0;
         res_periods_in = '0;
         unique case (req_ch.mode)
            pfpt_pkg::MODE_START: begin
               run_in = 1'b0;
               if (len != '0) begin
                  pos_in        = lead_clip[POS_W-1:0];
                  rem_in        = '0;
                  prog_in       = (cfg.period_frames != '0) ? PERIOD_W'(lead_clip) : '0;
                  run_in        = 1'b1;
                  res_frames_in = COUNT_W'(lead_clip);
               end
            end
            pfpt_pkg::MODE_STOP: begin
               run_in = 1'b0;
            end
            default: begin
            end
         endcase
      end

      // frames and remainder from the 10^9 split
      if (state_ff == pfpt_pkg::ST_NS && ns_done) begin
         rem_in    = ns_rem;
         frames_in = ns_quot;
      end

      // new position and period progress
      if (state_ff == pfpt_pkg::ST_WRAP && wrap_done) begin
         pos_in        = wrap_rem[POS_W-1:0];
         res_frames_in = pfpt_pkg::sat_count(WRAP_W'(frames_ff));
         if (cfg.period_frames != '0) begin
            prog_in = per_rem;
            if (!cfg.suppress) begin
               res_periods_in = pfpt_pkg::sat_count(per_quot);
            end
         end else begin
            prog_in = '0;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      out_frames_in  = out_frames_ff;
      out_periods_in = out_periods_ff;
      out_pos_in     = out_pos_ff;
      out_run_in     = out_run_ff;
      if (out_load) begin
         rsp_valid_in   = 1'b1;
         out_frames_in  = res_frames_ff;
         out_periods_in = res_periods_ff;
         out_pos_in     = pos_ff;
         out_run_in     = run_ff;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.frames_advanced = out_frames_ff;
   assign rsp_ch.periods_elapsed = out_periods_ff;
   assign rsp_ch.position        = out_pos_ff;
   assign rsp_ch.running         = out_run_ff;

   always_ff @(posedge clock) begin
      frames_ff      <= frames_in;
      res_frames_ff  <= res_frames_in;
      res_periods_ff <= res_periods_in;
      out_frames_ff  <= out_frames_in;
      out_periods_ff <= out_periods_in;
      out_pos_ff     <= out_pos_in;
      out_run_ff     <= out_run_in;
      if (reset) begin
         state_ff     <= pfpt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         rem_ff       <= '0;
         prog_ff      <= '0;
         run_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         rem_ff       <= rem_in;
         prog_ff      <= prog_in;
         run_ff       <= run_in;
      end
   end

   // position lands inside the ring after a wrap
   a_pos_in_ring: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfpt_pkg::ST_WRAP && wrap_done) |=> ({1'b0, pos_ff} < len))
      else $error("ring position not below length after wrap");

   // kept remainder stays below one second
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfpt_pkg::ST_NS && ns_done) |=> (rem_ff < pfpt_pkg::NS_PER_SECOND))
      else $error("nanosecond remainder out of range");

   // both wrap-stage dividers finish together
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfpt_pkg::ST_WRAP && wrap_done && cfg.period_frames != '0) |-> per_done)
      else $error("period divider out of step with ring divider");

   // a result only appears from the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == pfpt_pkg::ST_DONE))
      else $error("result raised outside done state");

endmodule
